/* sv/cbmirq_pkg.sv */
package cbmirq_pkg;

    localparam int CmdW = 3;
    localparam int AddrW = 16;
    localparam int DataW = 8;
    localparam int BankW = 19;
    localparam int DipW = 2;

    typedef logic [CmdW-1:0] cmd_t;

    // item commands
    localparam cmd_t CMD_CPU_WRITE = 3'd0;
    localparam cmd_t CMD_CPU_READ = 3'd1;
    localparam cmd_t CMD_CPU_CYCLE = 3'd2;
    localparam cmd_t CMD_PPU_READ = 3'd3;
    localparam cmd_t CMD_A12_RISE = 3'd4;
    localparam cmd_t CMD_PRG_LOOKUP = 3'd5;
    localparam cmd_t CMD_CHR_FETCH = 3'd6;

    // irq clock source, irq mode bits 1:0
    localparam logic [1:0] SRC_CPU_CYCLE = 2'd0;
    localparam logic [1:0] SRC_A12_RISE = 2'd1;
    localparam logic [1:0] SRC_PPU_READ = 2'd2;
    localparam logic [1:0] SRC_CPU_WRITE = 2'd3;

    // count direction, irq mode bits 7:6
    localparam logic [1:0] DIR_UP = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // cpu address regions, address bits 15:12
    localparam logic [3:0] REGION_ALU = 4'h5;
    localparam logic [3:0] REGION_PRG = 4'h8;
    localparam logic [3:0] REGION_CHR_LO = 4'h9;
    localparam logic [3:0] REGION_CHR_HI = 4'hA;
    localparam logic [3:0] REGION_IRQ = 4'hC;
    localparam logic [3:0] REGION_MODE = 4'hD;

    // 5000h area decode
    localparam logic [15:0] ALU_MASK = 16'h5803;
    localparam logic [15:0] ALU_FACTOR_A = 16'h5800;
    localparam logic [15:0] ALU_FACTOR_B = 16'h5801;
    localparam logic [15:0] ALU_SUM = 16'h5802;
    localparam logic [15:0] ALU_SCRATCH = 16'h5803;

    // irq register select, address bits 2:0
    localparam logic [2:0] IRQ_ENABLE = 3'd0;
    localparam logic [2:0] IRQ_MODE = 3'd1;
    localparam logic [2:0] IRQ_DISABLE = 3'd2;
    localparam logic [2:0] IRQ_ARM = 3'd3;
    localparam logic [2:0] IRQ_PRESCALE = 3'd4;
    localparam logic [2:0] IRQ_COUNT = 3'd5;
    localparam logic [2:0] IRQ_XOR = 3'd6;

    localparam logic [11:0] LATCH_KEY_MASK = 12'hFF8;
    localparam logic [11:0] LATCH_KEY_LO = 12'hFD8;
    localparam logic [11:0] LATCH_KEY_HI = 12'hFE8;

    function automatic logic [6:0] rev7(input logic [7:0] v);
        rev7 = {v[0], v[1], v[2], v[3], v[4], v[5], v[6]};
    endfunction

endpackage

/* sv/cbmirq_in_if.sv */
interface cbmirq_in_if;
    import cbmirq_pkg::*;

    logic valid;
    logic ready;
    logic [CmdW-1:0] command;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;

    modport source (output valid, command, address, data, input ready);
    modport sink (input valid, command, address, data, output ready);
endinterface

/* sv/cbmirq_out_if.sv */
interface cbmirq_out_if;
    import cbmirq_pkg::*;

    logic valid;
    logic ready;
    logic [DataW-1:0] read_data;
    logic irq_line;
    logic [BankW-1:0] bank_number;
    logic bank_is_ram;

    modport source (output valid, read_data, irq_line, bank_number, bank_is_ram,
                    input ready);
    modport sink (input valid, read_data, irq_line, bank_number, bank_is_ram,
                  output ready);
endinterface

/* sv/cartridge_bank_mapper_with_irq_timer_core.sv */
// Cartridge bank mapper with irq timer. Every command beat (cpu write, cpu read,
// clock event, prg lookup or chr fetch) is decoded combinationally against the
// register file and gives exactly one result beat from a single output register,
// in the cycle after acceptance. The block takes one beat per clock for as long as
// the result side keeps ready high; when a result is held, input ready drops
// until it is taken. irq_line is the irq pending level after the beat. The dip
// switch bits (read back on bits 7:6 of switch reads in the 5000h area) must be
// written through cfg_we/cfg_data only while the block is idle; it does not enforce this.
module cartridge_bank_mapper_with_irq_timer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cbmirq_pkg::DipW-1:0] cfg_data,
    cbmirq_in_if.sink                 items,
    cbmirq_out_if.source              results
);
    import cbmirq_pkg::*;

    logic [DipW-1:0] dip_reg;

    logic [7:0] factor_a_reg, factor_a_next;
    logic [7:0] factor_b_reg, factor_b_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] scratch_reg, scratch_next;
    logic [7:0] mode_reg [4];
    logic [7:0] mode_next [4];
    logic [7:0] prg_reg [4];
    logic [7:0] prg_next [4];
    logic [15:0] chr_reg [8];
    logic [15:0] chr_next [8];
    logic [2:0] latch_reg [2];
    logic [2:0] latch_next [2];
    logic irq_en_reg, irq_en_next;
    logic [7:0] irq_mode_reg, irq_mode_next;
    logic [7:0] prescale_reg, prescale_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic pending_reg, pending_next;

    logic out_valid_reg;
    logic [DataW-1:0] rd_reg, rd_next;
    logic [BankW-1:0] bank_reg, bank_next;
    logic ram_reg, ram_next;
    logic irq_line_reg;

    logic accept;
    logic tick_en;
    logic [7:0] tick_mask;
    logic [7:0] pre_step;
    logic [7:0] cnt_step;
    logic [15:0] product;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [1:0] slot;
    logic [7:0] tail_bank;
    logic [7:0] sel_bank;
    logic [BankW-1:0] prg_bank;
    logic [BankW-1:0] window;
    logic [2:0] cslot;
    logic [2:0] chr_idx;
    logic [15:0] chr_val;
    logic [BankW-1:0] chr_bank;
    logic [11:0] latch_key;

    assign addr = items.address;
    assign wdata = items.data;
    assign items.ready = !out_valid_reg || results.ready;
    assign accept = items.valid && items.ready;
    assign product = {8'd0, factor_a_reg} * {8'd0, factor_b_reg};

    // prg bank for the 8K slot the address falls in
    always_comb
    begin
        slot = addr[14:13];
        tail_bank = mode_reg[0][2] ? prg_reg[3] : 8'hFF;
        sel_bank = (slot == 2'd3) ? tail_bank : prg_reg[slot];
        case (mode_reg[0][1:0])
            2'd0: prg_bank = {9'd0, tail_bank, slot};
            2'd1: prg_bank = slot[1] ? {10'd0, tail_bank, slot[0]}
                                     : {10'd0, prg_reg[1], slot[0]};
            2'd2: prg_bank = {11'd0, sel_bank};
            default: prg_bank = {12'd0, rev7(sel_bank)};
        endcase
        case (mode_reg[0][1:0])
            2'd0: window = {9'd0, prg_reg[3], 2'b11};
            2'd1: window = {10'd0, prg_reg[3], 1'b1};
            2'd2: window = {11'd0, prg_reg[3]};
            default: window = {12'd0, rev7(prg_reg[3])};
        endcase
    end

    // chr bank, one register read through a mode-selected index
    always_comb
    begin
        cslot = addr[12:10];
        case (mode_reg[0][4:3])
            2'd0: chr_idx = 3'd0;
            2'd1: chr_idx = latch_reg[cslot[2]];
            2'd2: chr_idx = {cslot[2:1], 1'b0};
            default: chr_idx = cslot;
        endcase
        chr_val = chr_reg[chr_idx];
        case (mode_reg[0][4:3])
            2'd0: chr_bank = {chr_val, cslot};
            2'd1: chr_bank = {1'b0, chr_val, cslot[1:0]};
            2'd2: chr_bank = {2'b0, chr_val, cslot[0]};
            default: chr_bank = {3'b0, chr_val};
        endcase
        latch_key = addr[11:0] & LATCH_KEY_MASK;
    end

    always_comb
    begin
        factor_a_next = factor_a_reg;
        factor_b_next = factor_b_reg;
        sum_next = sum_reg;
        scratch_next = scratch_reg;
        mode_next = mode_reg;
        prg_next = prg_reg;
        chr_next = chr_reg;
        latch_next = latch_reg;
        irq_en_next = irq_en_reg;
        irq_mode_next = irq_mode_reg;
        prescale_next = prescale_reg;
        count_next = count_reg;
        xor_next = xor_reg;
        pending_next = pending_reg;
        rd_next = '0;
        bank_next = '0;
        ram_next = 1'b0;
        pre_step = prescale_reg;
        cnt_step = count_reg;

        case (items.command)
            CMD_CPU_WRITE: tick_en = (irq_mode_reg[1:0] == SRC_CPU_WRITE);
            CMD_CPU_CYCLE: tick_en = (irq_mode_reg[1:0] == SRC_CPU_CYCLE);
            CMD_PPU_READ: tick_en = (irq_mode_reg[1:0] == SRC_PPU_READ);
            CMD_A12_RISE: tick_en = (irq_mode_reg[1:0] == SRC_A12_RISE);
            default: tick_en = 1'b0;
        endcase
        tick_mask = irq_mode_reg[2] ? 8'h07 : 8'hFF;

        // timer tick comes before any register write of the same beat
        if (tick_en && irq_en_reg)
        begin
            if (irq_mode_reg[7:6] == DIR_UP)
            begin
                pre_step = prescale_reg + 8'd1;
                prescale_next = pre_step;
                if ((pre_step & tick_mask) == 8'h00)
                begin
                    if (!irq_mode_reg[3])
                        cnt_step = count_reg + 8'd1;
                    count_next = cnt_step;
                    if (cnt_step == 8'h00)
                        pending_next = 1'b1;
                end
            end
            else if (irq_mode_reg[7:6] == DIR_DOWN)
            begin
                pre_step = prescale_reg - 8'd1;
                prescale_next = pre_step;
                if ((pre_step & tick_mask) == tick_mask)
                begin
                    if (!irq_mode_reg[3])
                        cnt_step = count_reg - 8'd1;
                    count_next = cnt_step;
                    if (cnt_step == 8'hFF)
                        pending_next = 1'b1;
                end
            end
        end

        case (items.command)
            CMD_CPU_WRITE:
            begin
                case (addr[15:12])
                    REGION_ALU:
                    begin
                        case (addr & ALU_MASK)
                            ALU_FACTOR_A: factor_a_next = wdata;
                            ALU_FACTOR_B: factor_b_next = wdata;
                            ALU_SUM: sum_next = sum_reg + wdata;
                            ALU_SCRATCH:
                            begin
                                scratch_next = wdata;
                                sum_next = 8'h00;
                            end
                            default: ;
                        endcase
                    end
                    REGION_PRG:
                        if (!addr[11])
                            prg_next[addr[1:0]] = wdata;
                    REGION_CHR_LO:
                        if (!addr[11])
                            chr_next[addr[2:0]][7:0] = wdata;
                    REGION_CHR_HI:
                        if (!addr[11])
                            chr_next[addr[2:0]][15:8] = wdata;
                    REGION_IRQ:
                    begin
                        case (addr[2:0])
                            IRQ_ENABLE:
                            begin
                                irq_en_next = wdata[0];
                                if (!wdata[0])
                                begin
                                    prescale_next = 8'h00;
                                    pending_next = 1'b0;
                                end
                            end
                            IRQ_MODE: irq_mode_next = wdata;
                            IRQ_DISABLE:
                            begin
                                irq_en_next = 1'b0;
                                prescale_next = 8'h00;
                                pending_next = 1'b0;
                            end
                            IRQ_ARM: irq_en_next = 1'b1;
                            IRQ_PRESCALE: prescale_next = wdata ^ xor_reg;
                            IRQ_COUNT: count_next = wdata ^ xor_reg;
                            IRQ_XOR: xor_next = wdata;
                            default: ;
                        endcase
                    end
                    REGION_MODE:
                        if (!addr[11])
                            mode_next[addr[1:0]] = wdata;
                    default: ;
                endcase
            end
            CMD_CPU_READ:
            begin
                if (addr[15:12] != REGION_ALU)
                    rd_next = wdata;
                else if (addr[9:0] == 10'd0 && addr != ALU_FACTOR_A)
                    rd_next = {dip_reg, wdata[5:0]};
                else
                begin
                    case (addr & ALU_MASK)
                        ALU_FACTOR_A: rd_next = product[7:0];
                        ALU_FACTOR_B: rd_next = product[15:8];
                        ALU_SUM: rd_next = sum_reg;
                        ALU_SCRATCH: rd_next = scratch_reg;
                        default: rd_next = wdata;
                    endcase
                end
            end
            CMD_PRG_LOOKUP:
            begin
                if (addr[15])
                    bank_next = prg_bank;
                else if (addr[15:13] == 3'b011)
                begin
                    if (mode_reg[0][7])
                        bank_next = window;
                    else
                        ram_next = 1'b1;
                end
            end
            CMD_CHR_FETCH:
            begin
                bank_next = chr_bank;
                if (mode_reg[3][7] && (latch_key == LATCH_KEY_LO || latch_key == LATCH_KEY_HI))
                    latch_next[addr[12]] = {addr[6] & addr[12], addr[5], 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_reg <= '0;
            factor_a_reg <= '0;
            factor_b_reg <= '0;
            sum_reg <= '0;
            scratch_reg <= '0;
            mode_reg <= '{default: '0};
            prg_reg <= '{default: '0};
            chr_reg <= '{default: '0};
            latch_reg[0] <= 3'd0;
            latch_reg[1] <= 3'd4;
            irq_en_reg <= 1'b0;
            irq_mode_reg <= '0;
            prescale_reg <= '0;
            count_reg <= '0;
            xor_reg <= '0;
            pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            irq_line_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dip_reg <= cfg_data;
            if (accept)
            begin
                factor_a_reg <= factor_a_next;
                factor_b_reg <= factor_b_next;
                sum_reg <= sum_next;
                scratch_reg <= scratch_next;
                mode_reg <= mode_next;
                prg_reg <= prg_next;
                chr_reg <= chr_next;
                latch_reg <= latch_next;
                irq_en_reg <= irq_en_next;
                irq_mode_reg <= irq_mode_next;
                prescale_reg <= prescale_next;
                count_reg <= count_next;
                xor_reg <= xor_next;
                pending_reg <= pending_next;
                out_valid_reg <= 1'b1;
                irq_line_reg <= pending_next;
            end
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= rd_next;
            bank_reg <= bank_next;
            ram_reg <= ram_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.read_data = rd_reg;
    assign results.irq_line = irq_line_reg;
    assign results.bank_number = bank_reg;
    assign results.bank_is_ram = ram_reg;

`ifndef NO_ASSERTIONS
    // a disabled timer never leaves an irq pending
    a_pending_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        !irq_en_reg |-> !pending_reg)
        else $error("irq pending while timer disabled");

    // the low-half fetch latch can only hold 0 or 2
    a_latch0_range: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg[0][2] == 1'b0)
        else $error("chr fetch latch 0 out of range");

    // every accepted beat shows up as a result next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> results.valid)
        else $error("accepted beat gave no result");

    // the irq line of a result follows the pending state it was taken from
    a_irq_line_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> results.irq_line == pending_reg)
        else $error("irq line does not match pending state");
`endif

endmodule
